// File: sv/wts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg
// shared sizes, codes and control and status structs of the weighted table sampler
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int WEIGHT_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int SUM_W       = WEIGHT_W + IDX_W;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   localparam logic [1:0] ST_DRAWN    = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_APPENDED = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic start;
   } draw_ctl_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] pick;
   } draw_stat_type;

endpackage
`default_nettype wire

// File: sv/weighted_table_sampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_table_sampler_core
// roulette wheel selection over a table of running weight sums
// ----------------------------------------------------------------------------
// an append, a full append or an empty draw passes through the finish state into the
//   output register; a draw that picks entry k first multiplies and scans entries 0 to k
// a new word is taken only in idle, once the last result is loaded into the output register;
//   the scan compares one running sum per cycle from the table ram
// reset: synchronous, clears entry count, total, state and rsp_valid; table ram
//   contents are not cleared, only written entries are read
// ----------------------------------------------------------------------------
module weighted_table_sampler_core
   import wts_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_operation,
   input  wire logic [WEIGHT_W-1:0] req_weight,
   input  wire logic [FRAC_W-1:0]   req_random_fraction,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [3:0]          rsp_chosen_index,
   output logic      [1:0]          rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DRAW   = 3'b010,
      S_FINISH = 3'b100
   } top_state_type;

   // low four bits of a table index, zero filled when the index is narrower
   function automatic logic [3:0] index_field(input logic [IDX_W-1:0] idx);
      logic [IDX_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

   top_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_idx_ff;
   logic [1:0]       rsp_status_ff;

   logic             accept;
   logic             is_full;
   logic             out_free;
   logic             rsp_load;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [SUM_W-1:0] rd_data;
   draw_ctl_type     draw_ctl;
   draw_stat_type    draw_stat;

   // only idle takes a new word; the output register frees this from rsp_ready
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(MAX_ENTRIES));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == S_FINISH) && out_free;

   // sequencer: appends and empty draws finish at once, other draws hand off to the scan unit
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      res_idx_in     = res_idx_ff;
      res_status_in  = res_status_ff;
      wr_en          = 1'b0;
      draw_ctl.start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_FINISH;
               if (req_operation == OP_APPEND) begin
                  if (is_full) begin
                     // weight dropped, table left as it is
                     res_idx_in    = '0;
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     total_in      = total_ff + SUM_W'(req_weight);
                     count_in      = count_ff + CNT_W'(1);
                     res_idx_in    = count_ff[IDX_W-1:0];
                     res_status_in = ST_APPENDED;
                  end
               end else if (count_ff == '0) begin
                  res_idx_in    = '0;
                  res_status_in = ST_EMPTY;
               end else begin
                  draw_ctl.start = 1'b1;
                  state_in       = S_DRAW;
               end
            end
         end
         S_DRAW: begin
            if (draw_stat.done) begin
               res_idx_in    = draw_stat.pick;
               res_status_in = ST_DRAWN;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_idx_ff    <= index_field(res_idx_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_idx_ff;
   assign rsp_status       = rsp_status_ff;

   // running sums table
   wts_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (total_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // target multiply and shared compare scan
   wts_draw u_draw (
      .clock   (clock),
      .reset   (reset),
      .ctl     (draw_ctl),
      .frac    (req_random_fraction),
      .total   (total_ff),
      .count   (count_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (draw_stat)
   );

endmodule
`default_nettype wire

// File: sv/wts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/wts_draw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_draw
// draw unit: one multiply for the target, then one shared compare per entry
// ----------------------------------------------------------------------------
module wts_draw
   import wts_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire draw_ctl_type        ctl,
   input  wire logic [FRAC_W-1:0]   frac,
   input  wire logic [SUM_W-1:0]    total,
   input  wire logic [CNT_W-1:0]    count,
   output logic      [IDX_W-1:0]    rd_addr,
   input  wire logic [SUM_W-1:0]    rd_data,
   output draw_stat_type            stat
);

   localparam int PROD_W = FRAC_W + SUM_W;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_MUL  = 3'b010,
      D_SCAN = 3'b100
   } draw_state_type;

   draw_state_type    state_ff, state_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [SUM_W-1:0]  tot_ff, tot_in;
   logic [SUM_W-1:0]  target_ff, target_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PROD_W-1:0] product;
   logic              hit;
   logic              last;

   assign product = PROD_W'(frac_ff) * PROD_W'(tot_ff);
   assign hit     = rd_data > target_ff;
   assign last    = (CNT_W'(idx_ff) + CNT_W'(1)) == count;

   always_comb begin
      state_in  = state_ff;
      frac_in   = frac_ff;
      tot_in    = tot_ff;
      target_in = target_ff;
      idx_in    = idx_ff;
      rd_addr   = '0;
      stat.done = 1'b0;
      stat.pick = idx_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (ctl.start) begin
               frac_in  = frac;
               tot_in   = total;
               state_in = D_MUL;
            end
         end
         D_MUL: begin
            // entry zero is fetched while the product settles
            target_in = product[PROD_W-1:FRAC_W];
            idx_in    = '0;
            state_in  = D_SCAN;
         end
         D_SCAN: begin
            rd_addr = idx_ff + IDX_W'(1);
            if (hit || last) begin
               stat.done = 1'b1;
               state_in  = D_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      frac_ff   <= frac_in;
      tot_ff    <= tot_in;
      target_ff <= target_in;
      idx_ff    <= idx_in;
   end

endmodule
`default_nettype wire

// File: sv/wts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wts_checker
// port level checks of the sampler, bound to the top level
// ----------------------------------------------------------------------------
module wts_checker
   import wts_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_operation,
   input wire logic [WEIGHT_W-1:0] req_weight,
   input wire logic [FRAC_W-1:0]   req_random_fraction,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [3:0]          rsp_chosen_index,
   input wire logic [1:0]          rsp_status
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen_index)
         && $stable(rsp_status))
      else $error("stalled rsp word changed");

   // a waiting req word holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_operation)
         && $stable(req_weight) && $stable(req_random_fraction))
      else $error("waiting req word changed");

   // no word is left over from before reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // empty and full words carry index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
         |-> rsp_chosen_index == 4'd0)
      else $error("nonzero index on empty or full word");

   // req_ready is low in the cycle after every accepted word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accept");

endmodule

bind weighted_table_sampler_core wts_checker u_wts_checker (.*);
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives append and draw words into the weighted table sampler, predicts the
// chosen entry from a local copy of the running sums and checks every result
// word in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench
   import wts_pkg::*;
();

   // generous bound on the whole run
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_DRAWS = 1650;

   // receiver stall patterns
   localparam int RX_ALWAYS = 0;
   localparam int RX_LIGHT  = 1;
   localparam int RX_HEAVY  = 2;
   localparam int RX_COMB   = 3;

   typedef struct packed {
      logic [3:0] index;
      logic [1:0] status;
   } pick_word_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [WEIGHT_W-1:0] req_weight;
   logic [FRAC_W-1:0]   req_random_fraction;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [3:0]          rsp_chosen_index;
   logic [1:0]          rsp_status;

   // local copy of the table state
   logic [SUM_W-1:0] sum_table [MAX_ENTRIES];
   int               table_fill;

   pick_word_type pending_picks[$];
   int            mismatch_count;
   int            cycle_count;
   int            burst_left;
   int            stall_mode;
   int            hold_cycles;

   weighted_table_sampler_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_weight          (req_weight),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_status          (rsp_status)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor: updates the local table and returns the result word of one input
   // ---------------------------------------------------------------------------
   function automatic pick_word_type predict_pick(input logic op,
                                                  input logic [WEIGHT_W-1:0] w,
                                                  input logic [FRAC_W-1:0] f);
      pick_word_type             r;
      logic [SUM_W-1:0]          prev;
      logic [SUM_W-1:0]          total;
      logic [FRAC_W+SUM_W-1:0]   product;
      logic [SUM_W-1:0]          target;
      int                        pick;
      bit                        found;
      r = '0;
      if (op == OP_APPEND) begin
         if (table_fill >= MAX_ENTRIES) begin
            // full table drops the weight, index reads zero
            r.status = ST_FULL;
         end else begin
            prev = (table_fill == 0) ? '0 : sum_table[table_fill-1];
            sum_table[table_fill] = prev + SUM_W'(w);
            r.index  = 4'(table_fill);
            r.status = ST_APPENDED;
            table_fill++;
         end
      end else begin
         if (table_fill == 0) begin
            r.status = ST_EMPTY;
         end else begin
            total   = sum_table[table_fill-1];
            product = (FRAC_W+SUM_W)'(f) * (FRAC_W+SUM_W)'(total);
            target  = SUM_W'(product >> FRAC_W);
            // falls back to the last entry when nothing exceeds the target,
            // which covers an all-zero table
            pick  = table_fill - 1;
            found = 1'b0;
            for (int i = 0; i < table_fill; i++) begin
               if (!found && sum_table[i] > target) begin
                  pick  = i;
                  found = 1'b1;
               end
            end
            r.index  = 4'(pick);
            r.status = ST_DRAWN;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // offers one word from a falling edge, returns at the falling edge after accept;
   // valid stays high so a following call continues the burst
   task automatic send_word(input logic op, input logic [WEIGHT_W-1:0] w,
                            input logic [FRAC_W-1:0] f);
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_weight          <= w;
      req_random_fraction <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_picks.insert(pending_picks.size(), predict_pick(op, w, f));
      @(negedge clock);
   endtask

   // bursts of random length with idle gaps between them
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(negedge clock);
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return WEIGHT_W'($urandom_range(1, 15));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] pick_fraction();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // empty table, all-zero weights, largest weight and the exact total boundary
   task automatic test_edge_words();
      stall_mode = RX_LIGHT;
      send_word(OP_DRAW,   '0, '0);
      send_word(OP_DRAW,   '1, '1);
      send_word(OP_APPEND, '0, '1);
      send_word(OP_DRAW,   '0, '1);
      send_word(OP_APPEND, '0, '0);
      send_word(OP_DRAW,   '1, '0);
      pace_sender();
      send_word(OP_DRAW,   '0, '1);
      send_word(OP_APPEND, '1, '0);
      send_word(OP_DRAW,   '0, '0);
      send_word(OP_DRAW,   '0, '1);
      // sums 65535 then 65536: top fraction lands exactly on the first sum
      send_word(OP_APPEND, 16'd1, '0);
      send_word(OP_DRAW,   '0, '1);
      send_word(OP_DRAW,   '0, 16'h8000);
      pace_sender();
   endtask

   // interleaved appends and draws until the table is full, then dropped appends
   task automatic test_fill_table();
      stall_mode = RX_COMB;
      while (table_fill < MAX_ENTRIES) begin
         if ($urandom_range(0, 9) < 6)
            send_word(OP_APPEND, pick_weight(), FRAC_W'($urandom));
         else
            send_word(OP_DRAW, WEIGHT_W'($urandom), pick_fraction());
         pace_sender();
      end
      repeat (4) begin
         send_word(OP_APPEND, pick_weight(), FRAC_W'($urandom));
         pace_sender();
      end
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      stall_mode  = RX_ALWAYS;
      hold_cycles = 300;
      repeat (30) send_word(OP_DRAW, WEIGHT_W'($urandom), pick_fraction());
      pace_sender();
   endtask

   // sender stops until every result word is back, then resumes
   task automatic test_drain_pause();
      stall_mode = RX_HEAVY;
      repeat (10) begin
         send_word(OP_DRAW, WEIGHT_W'($urandom), pick_fraction());
         pace_sender();
      end
      wait_drained();
      repeat ($urandom_range(2, 20)) @(negedge clock);
      repeat (10) begin
         send_word(OP_DRAW, WEIGHT_W'($urandom), pick_fraction());
         pace_sender();
      end
   endtask

   // mostly draws over the full table, some appends that get dropped
   task automatic test_random_draws(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 200 == 0) stall_mode = (n / 200) % 4;
         if ($urandom_range(0, 9) == 0)
            send_word(OP_APPEND, WEIGHT_W'($urandom), FRAC_W'($urandom));
         else
            send_word(OP_DRAW, WEIGHT_W'($urandom), pick_fraction());
         pace_sender();
      end
   endtask

   // ---------------------------------------------------------------------------
   // receiver: stalls on its own pattern, or holds off for a counted stretch
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            case (stall_mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_LIGHT:  rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY:  rsp_ready <= ($urandom_range(0, 2) == 0);
               default:   rsp_ready <= ((cycle_count % 7) < 4);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result checking against the oldest pending prediction
   // ---------------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input pick_word_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected index %0d status %0d, got index %0d status %0d",
                  what, want.index, want.status, rsp_chosen_index, rsp_status);
   endtask

   always @(posedge clock) begin
      pick_word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            flag_mismatch("unexpected word", '0);
         end else begin
            due = pending_picks.pop_front();
            if (rsp_chosen_index !== due.index || rsp_status !== due.status)
               flag_mismatch("wrong field", due);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = OP_APPEND;
      req_weight          = '0;
      req_random_fraction = '0;
      mismatch_count      = 0;
      cycle_count         = 0;
      burst_left          = 0;
      stall_mode          = RX_ALWAYS;
      hold_cycles         = 0;
      table_fill          = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) sum_table[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edge_words();
      test_fill_table();
      test_backpressure();
      test_drain_pause();
      test_random_draws(RANDOM_DRAWS);

      // let the last words come back, then allow a full draw scan of slack
      wait_drained();
      stall_mode = RX_ALWAYS;
      repeat (40) @(negedge clock);

      if (mismatch_count == 0 && pending_picks.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
sv/wts_pkg.sv
sv/wts_ram.sv
sv/wts_draw.sv
sv/weighted_table_sampler_core.sv
sv/wts_checker.sv
sim/testbench.sv
